/* rtl/core/kstb_pkg.sv */
// ----------------------------------------------------------------------------
// kstb_pkg
// Types, codes and constants shared by the key scanner with typematic repeat
// and its port checker.
// ----------------------------------------------------------------------------
package kstb_pkg;

  // Field widths fixed by the item format.
  localparam int KEY_W   = 8;   // key code
  localparam int OP_W    = 3;   // operation code
  localparam int TOT_W   = 6;   // typed_total result field
  localparam int HC_W    = 16;  // hit counter, wraps at 16 bits
  localparam int CFG_W   = 8;   // configuration write data
  localparam int CIDX_W  = 2;   // configuration register index
  localparam int STEP_W  = 6;   // repeat step, 1 to 50
  localparam int BIT_W   = 4;   // bit index into the hit counter
  localparam int DDIV_W  = 4;   // repeat_delay_ticks / 20, at most 12

  // delay / 20 is computed as (delay * 205) >> 12, exact for 8-bit delays.
  localparam logic [15:0] DLY_RECIP = 16'd205;
  localparam int          DLY_SHIFT = 12;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN_SCAN  = 3'd0,
    OP_KEY_SAMPLE  = 3'd1,
    OP_END_SCAN    = 3'd2,
    OP_QUERY_DOWN  = 3'd3,
    OP_CONSUME_HIT = 3'd4,
    OP_DRAIN_TYPED = 3'd5
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_REPEAT_ENABLE = 2'd0,
    CFG_REPEAT_DELAY  = 2'd1,
    CFG_REPEAT_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_EDGE,
    ST_QRD,
    ST_QCMP,
    ST_CRD,
    ST_CCMP,
    ST_SHRD,
    ST_SHWR,
    ST_DRD,
    ST_DOUT,
    ST_RESULT,
    ST_MOD
  } state_t;

  // Repeat step 50 / period, with a zero period taken as 1 and a step of
  // zero (period above 50) raised to 1.
  function automatic logic [STEP_W-1:0] step_of(input logic [STEP_W-1:0] period);
    logic [STEP_W-1:0] s;
    case (period) inside
      6'd0, 6'd1:     s = 6'd50;
      6'd2:           s = 6'd25;
      6'd3:           s = 6'd16;
      6'd4:           s = 6'd12;
      6'd5:           s = 6'd10;
      6'd6:           s = 6'd8;
      6'd7:           s = 6'd7;
      6'd8:           s = 6'd6;
      [6'd9:6'd10]:   s = 6'd5;
      [6'd11:6'd12]:  s = 6'd4;
      [6'd13:6'd16]:  s = 6'd3;
      [6'd17:6'd25]:  s = 6'd2;
      default:        s = 6'd1;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/key_scan_typematic_buffer.sv */
// A key sample passes a sample state, plus an edge state for the press-edge write
// to the typed buffer; begin and end scan complete on acceptance. A query or a
// consume walks its list one entry at a time, and compaction after a hit reads
// and rewrites each moved entry. A drain reads each result over the typed memory
// read port. A write of repeat_period_ticks starts a remainder pass over the 16
// counter bits. Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_scan_typematic_buffer
// Keyboard scanner with typematic repeat, a down list and a typed buffer.
// ----------------------------------------------------------------------------
//
// The per-code press history, the down list and the typed buffer live in
// synchronous memories with registered read data. The press history is
// backed by a valid bit per code so that it reads as released after reset.
//
// The repeat test needs hit_counter modulo the repeat step. Rather than
// divide on every sample, the remainder is kept in its own register and
// stepped along with the hit counter. When the period register is written,
// the remainder is rebuilt by a restoring division over the sixteen counter
// bits, one bit per cycle.
//
// Items are processed one at a time. Results go through an output register,
// so the next item is accepted while a result still waits for its transfer.
module key_scan_typematic_buffer
  import kstb_pkg::*;
#(
  parameter int MAX_KEYS  = 32,
  parameter int NUM_CODES = 256
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [KEY_W-1:0]  in_key_code,
  input  logic              in_pressed,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_down,
  output logic              out_was_hit,
  output logic [KEY_W-1:0]  out_typed_key,
  output logic              out_typed_valid,
  output logic [TOT_W-1:0]  out_typed_total,
  output logic              out_last,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Entry index width and count width for the two key lists.
  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  // Address width of the press history.
  localparam int AW = $clog2(NUM_CODES);

  // Memories.
  logic             prev_mem [NUM_CODES];
  logic [KEY_W-1:0] down_mem [MAX_KEYS];
  logic [KEY_W-1:0] typed_mem [MAX_KEYS];

  logic [NUM_CODES-1:0] prev_vld_r, prev_vld_nxt;
  logic                 prev_rdata_r;
  logic [KEY_W-1:0]     down_rdata_r;
  logic [KEY_W-1:0]     typed_rdata_r;

  // Memory port controls.
  logic             p_rd_en, p_wr_en, p_wr_data;
  logic [AW-1:0]    p_rd_addr, p_wr_addr;
  logic             d_rd_en, d_wr_en;
  logic [IW-1:0]    d_rd_addr, d_wr_addr;
  logic [KEY_W-1:0] d_wr_data;
  logic             t_rd_en, t_wr_en;
  logic [IW-1:0]    t_rd_addr, t_wr_addr;
  logic [KEY_W-1:0] t_wr_data;

  // Control and working registers.
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [KEY_W-1:0]  code_r, code_nxt;
  logic              held_r, held_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     down_cnt_r, down_cnt_nxt;
  logic [CW-1:0]     typed_cnt_r, typed_cnt_nxt;
  logic [HC_W-1:0]   hit_r, hit_nxt;
  logic [STEP_W-1:0] mod_r, mod_nxt;
  logic [BIT_W-1:0]  mbit_r, mbit_nxt;

  // Configuration, kept in the form the repeat test uses.
  logic              rep_en_r, rep_en_nxt;
  logic [DDIV_W-1:0] delay_div_r, delay_div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_down_r, out_is_down_nxt;
  logic              out_was_hit_r, out_was_hit_nxt;
  logic [KEY_W-1:0]  out_typed_key_r, out_typed_key_nxt;
  logic              out_typed_valid_r, out_typed_valid_nxt;
  logic [TOT_W-1:0]  out_typed_total_r, out_typed_total_nxt;
  logic              out_last_r, out_last_nxt;

  // Helpers.
  logic              in_fire, cfg_fire, out_free;
  logic              t_full;
  logic [IW-1:0]     t_push_addr;
  logic [CW-1:0]     t_push_cnt;
  logic [CW-1:0]     idx_inc;
  logic              rep_fire;
  logic              prev_pressed;
  logic [15:0]       dly_prod;
  logic [STEP_W:0]   rem_sh;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;

  // A push into a full typed buffer empties it first.
  assign t_full      = (typed_cnt_r >= CW'(MAX_KEYS));
  assign t_push_addr = t_full ? '0 : typed_cnt_r[IW-1:0];
  assign t_push_cnt  = t_full ? CW'(1) : typed_cnt_r + CW'(1);

  assign idx_inc  = idx_r + CW'(1);
  assign rep_fire = rep_en_r && (hit_r > HC_W'(delay_div_r)) && (mod_r == '0);
  assign prev_pressed = prev_vld_r[code_r[AW-1:0]] && prev_rdata_r;
  assign dly_prod = 16'(cfg_wdata) * DLY_RECIP;
  assign rem_sh   = {mod_r, hit_r[mbit_r]};

  always_comb begin
    state_nxt           = state_r;
    op_nxt              = op_r;
    code_nxt            = code_r;
    held_nxt            = held_r;
    idx_nxt             = idx_r;
    total_nxt           = total_r;
    found_nxt           = found_r;
    down_cnt_nxt        = down_cnt_r;
    typed_cnt_nxt       = typed_cnt_r;
    hit_nxt             = hit_r;
    mod_nxt             = mod_r;
    mbit_nxt            = mbit_r;
    rep_en_nxt          = rep_en_r;
    delay_div_nxt       = delay_div_r;
    step_nxt            = step_r;
    prev_vld_nxt        = prev_vld_r;

    out_valid_nxt       = out_valid_r && !out_ready;
    out_is_down_nxt     = out_is_down_r;
    out_was_hit_nxt     = out_was_hit_r;
    out_typed_key_nxt   = out_typed_key_r;
    out_typed_valid_nxt = out_typed_valid_r;
    out_typed_total_nxt = out_typed_total_r;
    out_last_nxt        = out_last_r;

    p_rd_en   = 1'b0;
    p_rd_addr = in_key_code[AW-1:0];
    p_wr_en   = 1'b0;
    p_wr_addr = code_r[AW-1:0];
    p_wr_data = held_r;
    d_rd_en   = 1'b0;
    d_rd_addr = idx_r[IW-1:0];
    d_wr_en   = 1'b0;
    d_wr_addr = down_cnt_r[IW-1:0];
    d_wr_data = code_r;
    t_rd_en   = 1'b0;
    t_rd_addr = idx_r[IW-1:0];
    t_wr_en   = 1'b0;
    t_wr_addr = t_push_addr;
    t_wr_data = code_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          case (cfg_index)
            CFG_REPEAT_ENABLE: rep_en_nxt = cfg_wdata[0];
            CFG_REPEAT_DELAY:  delay_div_nxt = dly_prod[DLY_SHIFT +: DDIV_W];
            CFG_REPEAT_PERIOD: begin
              // The remainder must be rebuilt against the new step.
              step_nxt  = step_of(cfg_wdata[STEP_W-1:0]);
              mod_nxt   = '0;
              mbit_nxt  = BIT_W'(HC_W - 1);
              state_nxt = ST_MOD;
            end
            default: ;
          endcase
        end else if (in_fire) begin
          op_nxt    = op_t'(in_operation);
          code_nxt  = in_key_code;
          held_nxt  = in_pressed;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          case (op_t'(in_operation))
            OP_BEGIN_SCAN: down_cnt_nxt = '0;
            OP_KEY_SAMPLE: begin
              // Codes outside the scanned range are dropped without a trace.
              if ({1'b0, in_key_code} < (KEY_W + 1)'(NUM_CODES)) begin
                p_rd_en   = 1'b1;
                state_nxt = ST_SAMPLE;
              end
            end
            OP_END_SCAN: begin
              if (hit_r == '1) begin
                hit_nxt = '0;
                mod_nxt = '0;
              end else begin
                hit_nxt = hit_r + HC_W'(1);
                mod_nxt = (mod_r + STEP_W'(1) == step_r) ? '0 : mod_r + STEP_W'(1);
              end
            end
            OP_QUERY_DOWN:  state_nxt = ST_QRD;
            OP_CONSUME_HIT: state_nxt = ST_CRD;
            OP_DRAIN_TYPED: begin
              total_nxt     = typed_cnt_r;
              typed_cnt_nxt = '0;
              state_nxt     = (typed_cnt_r == '0) ? ST_RESULT : ST_DRD;
            end
            default: ;
          endcase
        end
      end

      ST_SAMPLE: begin
        p_wr_en = 1'b1;
        prev_vld_nxt[code_r[AW-1:0]] = 1'b1;
        state_nxt = ST_IDLE;
        if (held_r) begin
          if (down_cnt_r < CW'(MAX_KEYS)) begin
            d_wr_en      = 1'b1;
            down_cnt_nxt = down_cnt_r + CW'(1);
          end
          // The repeat goes in ahead of the press-edge entry.
          if (rep_fire) begin
            t_wr_en       = 1'b1;
            typed_cnt_nxt = t_push_cnt;
          end
          if (!prev_pressed) begin
            state_nxt = ST_EDGE;
          end
        end
      end

      ST_EDGE: begin
        t_wr_en       = 1'b1;
        typed_cnt_nxt = t_push_cnt;
        hit_nxt       = '0;
        mod_nxt       = '0;
        state_nxt     = ST_IDLE;
      end

      ST_QRD: begin
        if (idx_r >= down_cnt_r) begin
          state_nxt = ST_RESULT;
        end else begin
          d_rd_en   = 1'b1;
          state_nxt = ST_QCMP;
        end
      end

      ST_QCMP: begin
        if (down_rdata_r == code_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_QRD;
        end
      end

      ST_CRD: begin
        if (idx_r >= typed_cnt_r) begin
          state_nxt = ST_RESULT;
        end else begin
          t_rd_en   = 1'b1;
          state_nxt = ST_CCMP;
        end
      end

      ST_CCMP: begin
        if (typed_rdata_r == code_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_SHRD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_CRD;
        end
      end

      // Compaction: move each later entry down by one.
      ST_SHRD: begin
        if (idx_inc >= typed_cnt_r) begin
          typed_cnt_nxt = typed_cnt_r - CW'(1);
          state_nxt     = ST_RESULT;
        end else begin
          t_rd_en   = 1'b1;
          t_rd_addr = idx_inc[IW-1:0];
          state_nxt = ST_SHWR;
        end
      end

      ST_SHWR: begin
        t_wr_en   = 1'b1;
        t_wr_addr = idx_r[IW-1:0];
        t_wr_data = typed_rdata_r;
        idx_nxt   = idx_inc;
        state_nxt = ST_SHRD;
      end

      ST_DRD: begin
        t_rd_en   = 1'b1;
        state_nxt = ST_DOUT;
      end

      ST_DOUT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_is_down_nxt     = 1'b0;
          out_was_hit_nxt     = 1'b0;
          out_typed_key_nxt   = typed_rdata_r;
          out_typed_valid_nxt = 1'b1;
          out_typed_total_nxt = TOT_W'(total_r);
          out_last_nxt        = (idx_inc == total_r);
          idx_nxt             = idx_inc;
          state_nxt           = (idx_inc == total_r) ? ST_IDLE : ST_DRD;
        end
      end

      // Single result of a query, a consume or an empty drain.
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_is_down_nxt     = (op_r == OP_QUERY_DOWN) && found_r;
          out_was_hit_nxt     = (op_r == OP_CONSUME_HIT) && found_r;
          out_typed_key_nxt   = '0;
          out_typed_valid_nxt = 1'b0;
          out_typed_total_nxt = '0;
          out_last_nxt        = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      // Restoring remainder, most significant counter bit first.
      ST_MOD: begin
        if (rem_sh >= {1'b0, step_r}) begin
          mod_nxt = STEP_W'(rem_sh - {1'b0, step_r});
        end else begin
          mod_nxt = rem_sh[STEP_W-1:0];
        end
        mbit_nxt = mbit_r - BIT_W'(1);
        if (mbit_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (p_rd_en) begin
      prev_rdata_r <= prev_mem[p_rd_addr];
    end
    if (p_wr_en) begin
      prev_mem[p_wr_addr] <= p_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rd_en) begin
      down_rdata_r <= down_mem[d_rd_addr];
    end
    if (d_wr_en) begin
      down_mem[d_wr_addr] <= d_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (t_rd_en) begin
      typed_rdata_r <= typed_mem[t_rd_addr];
    end
    if (t_wr_en) begin
      typed_mem[t_wr_addr] <= t_wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      down_cnt_r  <= '0;
      typed_cnt_r <= '0;
      hit_r       <= '0;
      mod_r       <= '0;
      rep_en_r    <= 1'b0;
      delay_div_r <= '0;
      step_r      <= step_of(6'd50);
      prev_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      down_cnt_r  <= down_cnt_nxt;
      typed_cnt_r <= typed_cnt_nxt;
      hit_r       <= hit_nxt;
      mod_r       <= mod_nxt;
      rep_en_r    <= rep_en_nxt;
      delay_div_r <= delay_div_nxt;
      step_r      <= step_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    op_r              <= op_nxt;
    code_r            <= code_nxt;
    held_r            <= held_nxt;
    idx_r             <= idx_nxt;
    total_r           <= total_nxt;
    found_r           <= found_nxt;
    mbit_r            <= mbit_nxt;
    out_is_down_r     <= out_is_down_nxt;
    out_was_hit_r     <= out_was_hit_nxt;
    out_typed_key_r   <= out_typed_key_nxt;
    out_typed_valid_r <= out_typed_valid_nxt;
    out_typed_total_r <= out_typed_total_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_is_down     = out_is_down_r;
  assign out_was_hit     = out_was_hit_r;
  assign out_typed_key   = out_typed_key_r;
  assign out_typed_valid = out_typed_valid_r;
  assign out_typed_total = out_typed_total_r;
  assign out_last        = out_last_r;

endmodule

/* rtl/core/kstb_checker.sv */
// ----------------------------------------------------------------------------
// kstb_checker
// Port-level checks for the key scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module kstb_checker
  import kstb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_is_down,
  input logic             out_was_hit,
  input logic [KEY_W-1:0] out_typed_key,
  input logic             out_typed_valid,
  input logic [TOT_W-1:0] out_typed_total,
  input logic             out_last
);

  // A stalled result holds its valid, typed key, last flag and typed total.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_typed_key) &&
      $stable(out_last) && $stable(out_typed_total))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A drained key always comes with a nonzero count and the down and hit flags clear.
  a_drain_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_typed_valid |-> out_typed_total != '0 &&
      !out_is_down && !out_was_hit)
    else $error("drained key with bad count or flags");

  // Query, consume and empty drain results are the only result of their item and carry a zero count.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_typed_valid |-> out_last && out_typed_total == '0)
    else $error("single result not marked last");

endmodule

bind key_scan_typematic_buffer kstb_checker u_kstb_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key scanner with typematic repeat. It drives
// scan, query, consume and drain items into the block, keeps its own model of
// the press history, down list, typed buffer and hit counter, and compares
// every result transfer field by field against the model's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import kstb_pkg::*;

  // Operation codes that the block has no use for. They must be ignored.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int DOWN_DEPTH  = 32;    // down list entries
  localparam int TYPED_DEPTH = 32;    // typed buffer entries
  localparam int CODE_COUNT  = 256;   // key codes covered by one scan
  localparam int DELAY_DIV   = 20;    // divisor applied to the delay register
  localparam int RATE_BASE   = 50;    // repeat step is this over the period
  // Cycles to let pass after the last result before the block counts as idle.
  // Only a trailing key sample may still be running then.
  localparam int SETTLE_CYCLES = 160;
  localparam int PRINT_LIMIT   = 40;

  // One result transfer, one member per result port.
  typedef struct packed {
    logic              is_down;
    logic              was_hit;
    logic [KEY_W-1:0]  typed_key;
    logic              typed_valid;
    logic [TOT_W-1:0]  typed_total;
    logic              last;
  } key_result_t;

  // Clock and reset. Reset starts low and is released by the main sequence.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // Block inputs start from known values.
  logic              in_valid     = 1'b0;
  logic [OP_W-1:0]   in_operation = '0;
  logic [KEY_W-1:0]  in_key_code  = '0;
  logic              in_pressed   = 1'b0;
  logic              out_ready    = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic [CIDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]  cfg_wdata    = '0;

  logic              in_ready;
  logic              out_valid;
  logic              out_is_down;
  logic              out_was_hit;
  logic [KEY_W-1:0]  out_typed_key;
  logic              out_typed_valid;
  logic [TOT_W-1:0]  out_typed_total;
  logic              out_last;
  logic              cfg_ready;

  key_scan_typematic_buffer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key_code     (in_key_code),
    .in_pressed      (in_pressed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_down     (out_is_down),
    .out_was_hit     (out_was_hit),
    .out_typed_key   (out_typed_key),
    .out_typed_valid (out_typed_valid),
    .out_typed_total (out_typed_total),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Keyboard state as the bench believes it to be. It is updated at the edge
  // where an item transfer completes, so it always matches the order in which
  // the block saw the items.
  // --------------------------------------------------------------------------
  logic              key_was_held [CODE_COUNT];
  logic [KEY_W-1:0]  down_codes [DOWN_DEPTH];
  int unsigned       down_n   = 0;
  logic [KEY_W-1:0]  typed_codes [TYPED_DEPTH];
  int unsigned       typed_n  = 0;
  logic [HC_W-1:0]   hit_ticks = '0;
  logic              rep_enable = 1'b0;
  logic [7:0]        rep_delay  = 8'd0;
  logic [5:0]        rep_period = 6'd50;

  // Results the block still owes, oldest first.
  key_result_t results_due [$];

  int fail_count     = 0;
  int results_seen   = 0;
  int items_accepted = 0;
  int scans_walked   = 0;

  // Idling controls for the two sides of the block.
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;
  int stall_left = 0;

  // A full typed buffer is emptied before the new code goes in.
  task automatic append_typed(input logic [KEY_W-1:0] code);
    if (typed_n >= TYPED_DEPTH)
      typed_n = 0;
    typed_codes[typed_n] = code;
    typed_n++;
  endtask

  // Work out the state change and the results of one accepted item.
  task automatic track_key_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] code,
                                input logic held);
    key_result_t r;
    int unsigned rep_step;
    int unsigned total;
    bit found;
    r = '0;
    case (op)
      OP_BEGIN_SCAN: begin
        down_n = 0;
      end
      OP_KEY_SAMPLE: begin
        if (int'(code) < CODE_COUNT) begin
          if (held) begin
            if (down_n < DOWN_DEPTH) begin
              down_codes[down_n] = code;
              down_n++;
            end
            // A zero period counts as one, and a step that rounds down to
            // zero is raised to one.
            rep_step = RATE_BASE / ((rep_period == 0) ? 1 : rep_period);
            if (rep_step == 0)
              rep_step = 1;
            if (rep_enable && hit_ticks > rep_delay / DELAY_DIV && hit_ticks % rep_step == 0)
              append_typed(code);
            if (!key_was_held[code]) begin
              append_typed(code);
              hit_ticks = '0;
            end
          end
          key_was_held[code] = held;
        end
      end
      OP_END_SCAN: begin
        hit_ticks = hit_ticks + 1'b1;
      end
      OP_QUERY_DOWN: begin
        for (int i = 0; i < down_n; i++)
          if (down_codes[i] == code)
            r.is_down = 1'b1;
        r.last = 1'b1;
        results_due.push_back(r);
      end
      OP_CONSUME_HIT: begin
        found = 1'b0;
        for (int i = 0; i < typed_n && !found; i++) begin
          if (typed_codes[i] == code) begin
            for (int j = i; j + 1 < typed_n; j++)
              typed_codes[j] = typed_codes[j + 1];
            found = 1'b1;
          end
        end
        if (found)
          typed_n--;
        r.was_hit = found;
        r.last    = 1'b1;
        results_due.push_back(r);
      end
      OP_DRAIN_TYPED: begin
        total   = typed_n;
        typed_n = 0;
        if (total == 0) begin
          r.last = 1'b1;
          results_due.push_back(r);
        end else begin
          for (int i = 0; i < total; i++) begin
            r             = '0;
            r.typed_key   = typed_codes[i];
            r.typed_valid = 1'b1;
            r.typed_total = total[TOT_W-1:0];
            r.last        = (i + 1 == total);
            results_due.push_back(r);
          end
        end
      end
      default: begin
        // The spare codes leave the block untouched.
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Result side. Each completed result transfer is matched against the oldest
  // outstanding prediction. Values are sampled at the edge, before the block's
  // own updates from that edge take effect.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result transfer with no result outstanding");
      end else begin
        want = results_due.pop_front();
        check_field("is_down",     out_is_down,     want.is_down);
        check_field("was_hit",     out_was_hit,     want.was_hit);
        check_field("typed_key",   out_typed_key,   want.typed_key);
        check_field("typed_valid", out_typed_valid, want.typed_valid);
        check_field("typed_total", out_typed_total, want.typed_total);
        check_field("last",        out_last,        want.last);
      end
      results_seen++;
    end
  end

  // Back-pressure on the result side. Stalls come in bursts of random length;
  // with stalls off, ready stays high once any running burst has ended.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Valid is left high after a transfer so that back-to-back items
  // keep it asserted; it is lowered only for a gap or when the bench goes
  // quiet to wait for the block.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] code,
                           input logic held);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_code  <= code;
    in_pressed   <= held;
    do @(posedge clk); while (!in_ready);
    track_key_item(op, code, held);
    if (op != OP_SPARE_6 && op != OP_SPARE_7)
      items_accepted++;
  endtask

  // Stop sending, collect every outstanding result, then give the block time
  // to finish work that produces no result (scan items).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transfer. Valid is left high for a following write.
  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REPEAT_ENABLE: rep_enable = data[0];
      CFG_REPEAT_DELAY:  rep_delay  = data;
      CFG_REPEAT_PERIOD: rep_period = data[5:0];
      default: ;
    endcase
  endtask

  // Program all three registers while the block sits idle.
  task automatic write_settings(input logic en, input logic [7:0] dly, input logic [5:0] per);
    wait_idle();
    cfg_write(CFG_REPEAT_ENABLE, {7'd0, en});
    cfg_write(CFG_REPEAT_DELAY, dly);
    cfg_write(CFG_REPEAT_PERIOD, {2'd0, per});
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: empty lists, extreme codes, spare operations, a consume
  // hit and miss, a held key with repeat off, and a release then re-press.
  task automatic test_basic_items();
    send_item(OP_DRAIN_TYPED, 8'd0, 1'b0);       // drain of an empty buffer
    send_item(OP_QUERY_DOWN, 8'd0, 1'b0);
    send_item(OP_CONSUME_HIT, 8'd255, 1'b1);
    send_item(OP_SPARE_6, 8'd255, 1'b1);
    send_item(OP_SPARE_7, 8'd0, 1'b1);
    send_item(OP_BEGIN_SCAN, 8'd0, 1'b0);
    send_item(OP_KEY_SAMPLE, 8'd0, 1'b1);
    send_item(OP_KEY_SAMPLE, 8'd255, 1'b1);
    send_item(OP_KEY_SAMPLE, 8'd7, 1'b0);
    send_item(OP_END_SCAN, 8'd0, 1'b0);
    send_item(OP_QUERY_DOWN, 8'd0, 1'b0);
    send_item(OP_QUERY_DOWN, 8'd255, 1'b0);
    send_item(OP_QUERY_DOWN, 8'd7, 1'b0);
    send_item(OP_CONSUME_HIT, 8'd255, 1'b0);
    send_item(OP_CONSUME_HIT, 8'd255, 1'b0);
    send_item(OP_KEY_SAMPLE, 8'd0, 1'b1);         // still held, no new edge
    send_item(OP_DRAIN_TYPED, 8'd0, 1'b0);
    send_item(OP_KEY_SAMPLE, 8'd0, 1'b0);
    send_item(OP_KEY_SAMPLE, 8'd0, 1'b1);         // pressed again
    send_item(OP_DRAIN_TYPED, 8'd0, 1'b0);
  endtask

  // Thirty-four fresh presses in one scan overrun both lists: the down list
  // stops at its depth and the typed buffer wraps to empty before refilling.
  task automatic test_list_capacity();
    send_item(OP_BEGIN_SCAN, 8'd0, 1'b0);
    for (int c = 64; c < 98; c++)
      send_item(OP_KEY_SAMPLE, c[7:0], 1'b1);
    send_item(OP_QUERY_DOWN, 8'd95, 1'b0);
    send_item(OP_QUERY_DOWN, 8'd96, 1'b0);
    send_item(OP_CONSUME_HIT, 8'd64, 1'b0);
    send_item(OP_DRAIN_TYPED, 8'd0, 1'b0);
  endtask

  // A key held over many scans with the longest delay and the slowest rate:
  // repeats only once the counter passes the delay and hits a multiple of 50.
  task automatic test_typematic_hold();
    write_settings(1'b1, 8'd255, 6'd1);
    send_item(OP_BEGIN_SCAN, 8'd0, 1'b0);
    send_item(OP_KEY_SAMPLE, 8'd170, 1'b1);
    for (int s = 0; s < 52; s++) begin
      send_item(OP_END_SCAN, 8'd0, 1'b0);
      send_item(OP_KEY_SAMPLE, 8'd170, 1'b1);
    end
    send_item(OP_QUERY_DOWN, 8'd170, 1'b0);
    send_item(OP_QUERY_DOWN, 8'd85, 1'b0);
    send_item(OP_DRAIN_TYPED, 8'd0, 1'b0);
  endtask

  // Random traffic under one register setting. Most of it is complete scans
  // over a small set of keys whose held state changes now and then, so press
  // edges, holds and repeats all occur; the rest is queries, consumes,
  // drains, scans missing their begin item, and arbitrary items.
  task automatic test_random_phase(input logic en, input logic [7:0] dly, input logic [5:0] per,
                                   input int quota, input bit quiet);
    logic [KEY_W-1:0] scan_keys [5];
    bit               held_now  [5];
    logic [KEY_W-1:0] code;
    int start, kind;
    write_settings(en, dly, per);
    for (int k = 0; k < 5; k++) begin
      scan_keys[k] = $urandom_range(0, 255);
      held_now[k]  = $urandom_range(0, 1);
    end
    scan_keys[0] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    gaps_on   = !quiet;
    stalls_on = !quiet;
    start = items_accepted;
    while (items_accepted - start < quota) begin
      if (!quiet && $urandom_range(0, 7) == 0)
        gaps_on = !gaps_on;
      if (!quiet && $urandom_range(0, 7) == 0)
        stalls_on = !stalls_on;
      kind = $urandom_range(0, 19);
      code = $urandom_range(0, 3) != 0 ? scan_keys[$urandom_range(0, 4)]
                                       : 8'($urandom_range(0, 255));
      if (kind <= 10) begin
        if (kind != 10)
          send_item(OP_BEGIN_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int k = 0; k < 5; k++) begin
          if ($urandom_range(0, 3) == 0)
            held_now[k] = !held_now[k];
          send_item(OP_KEY_SAMPLE, scan_keys[k], held_now[k]);
        end
        send_item(OP_END_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        scans_walked++;
      end else if (kind <= 13) begin
        send_item(OP_QUERY_DOWN, code, 1'($urandom_range(0, 1)));
      end else if (kind <= 16) begin
        send_item(OP_CONSUME_HIT, code, 1'($urandom_range(0, 1)));
      end else if (kind == 17) begin
        send_item(OP_DRAIN_TYPED, code, 1'($urandom_range(0, 1)));
      end else begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < CODE_COUNT; c++)
      key_was_held[c] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_items();
    test_list_capacity();
    test_typematic_hold();
    // Settings run from no repeat to the fastest and slowest rates, with a
    // zero period and a period above 50 among them. The last phase runs
    // with no gaps and no stalls.
    test_random_phase(1'b1, 8'd0, 6'd50, 45, 1'b0);
    test_random_phase(1'b1, 8'd255, 6'd1, 45, 1'b0);
    test_random_phase(1'b1, 8'd40, 6'd0, 45, 1'b0);
    test_random_phase(1'b1, 8'd20, 6'd63, 45, 1'b0);
    test_random_phase(1'b0, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 45, 1'b0);
    test_random_phase(1'b1, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 45, 1'b1);

    wait_idle();
    $display("Checked %0d result transfers from %0d accepted items, %0d random scans.",
             results_seen, items_accepted, scans_walked);
    $display("Covered list overflow, long typematic holds and zero or oversized periods.");
    if (fail_count == 0) begin
      $display("** key_scan_typematic_buffer: PASSED **");
    end else begin
      $display("** key_scan_typematic_buffer: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("Timeout: %0d results still outstanding.", results_due.size());
    $display("** key_scan_typematic_buffer: FAILED **");
    $finish;
  end

endmodule

/* key_scan_typematic_buffer.f */
rtl/core/kstb_pkg.sv
rtl/core/key_scan_typematic_buffer.sv
rtl/core/kstb_checker.sv
test/tb_top.sv
